// ----- src/rc_receiver_frame_decoder_assert.svh -----
// Assertion macros for the RC receiver frame decoder checker.
// Depends on nothing; included by the checker file.
`ifndef RC_RECEIVER_FRAME_DECODER_ASSERT_SVH
`define RC_RECEIVER_FRAME_DECODER_ASSERT_SVH

// Condition holds in the same cycle as the trigger.
`define RCFD_ASSERT_SAME(name, clk_i, rst_ni, ante, cons) \
	name: assert property (@(posedge clk_i) disable iff (!(rst_ni)) (ante) |-> (cons)) \
		else $error("rcfd assertion failed");

// Condition holds in the cycle after the trigger.
`define RCFD_ASSERT_NEXT(name, clk_i, rst_ni, ante, cons) \
	name: assert property (@(posedge clk_i) disable iff (!(rst_ni)) (ante) |=> (cons)) \
		else $error("rcfd assertion failed");

`endif

// ----- src/rcfd_pkg.sv -----
// Shared types and constants of the RC receiver frame decoder.
// Used by the controller, the datapath, the top level and the checker.
package rcfd_pkg;

	localparam logic [7:0]  SYSTEM_FIELD_RST    = 8'hB2;
	localparam logic [4:0]  CHANNEL_COUNT       = 5'd12;
	localparam int unsigned WORDS_PER_FRAME_DEF = 7;
	localparam logic [17:0] POS_SCALE           = 18'd125;
	localparam logic [17:0] NORM_OFFSET         = 18'd128000;

	typedef enum logic [1:0] {
		ST_FADES,
		ST_SYSTEM,
		ST_DATA,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic store;
		logic load;
	} cmd_t;

	typedef struct packed {
		logic sys_match;
		logic last_byte;
		logic last_word;
	} status_t;

endpackage

// ----- src/rcfd_ctrl.sv -----
// Frame sequencer of the RC receiver frame decoder.
// Depends on rcfd_pkg; drives the datapath through cmd_t, reads status_t.
module rcfd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  rcfd_pkg::status_t status,
	output rcfd_pkg::cmd_t    cmd
);
	import rcfd_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_FADES;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		cmd.store = 1'b0;
		cmd.load  = 1'b0;
		unique case (state_q)
			ST_FADES: begin
				in_ready = 1'b1;
				if (in_valid) state_d = ST_SYSTEM;
			end
			ST_SYSTEM: begin
				// a mismatching byte stands in as the new fades byte
				in_ready = 1'b1;
				if (in_valid && status.sys_match) state_d = ST_DATA;
			end
			ST_DATA: begin
				in_ready  = 1'b1;
				cmd.store = in_valid;
				if (in_valid && status.last_byte) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				cmd.load = !out_valid_q || out_ready;
				if (cmd.load && status.last_word) state_d = ST_FADES;
			end
			default: state_d = ST_FADES;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

// ----- src/rcfd_datapath.sv -----
// Byte store, word decode and output register of the RC receiver frame decoder.
// Depends on rcfd_pkg; commanded by rcfd_ctrl.
module rcfd_datapath #(
	parameter int unsigned WORDS_PER_FRAME = rcfd_pkg::WORDS_PER_FRAME_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_write,
	input  logic [7:0]          system_field,
	input  logic [7:0]          rx_byte,
	input  rcfd_pkg::cmd_t      cmd,
	output rcfd_pkg::status_t   status,
	output logic [3:0]          channel_index,
	output logic [10:0]         position,
	output logic                in_range,
	output logic signed [17:0]  normalized_q7,
	output logic                last
);
	import rcfd_pkg::*;

	localparam int unsigned IdxW = (WORDS_PER_FRAME > 1) ? $clog2(WORDS_PER_FRAME) : 1;
	localparam logic [IdxW-1:0] LastIdx = IdxW'(WORDS_PER_FRAME - 1);

	logic [7:0]      sys_q;
	logic [IdxW-1:0] idx_q;
	logic            half_q;
	logic [15:0]     word_q [WORDS_PER_FRAME];

	logic [15:0] rd_word;
	logic [3:0]  rd_chan;
	logic [10:0] rd_pos;
	logic        rd_ok;
	logic [17:0] prod;
	logic        at_last;

	logic [3:0]         chan_q;
	logic [10:0]        pos_q;
	logic               ok_q;
	logic signed [17:0] norm_q;
	logic               last_q;

	assign at_last = (idx_q == LastIdx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sys_q  <= SYSTEM_FIELD_RST;
			idx_q  <= '0;
			half_q <= 1'b0;
		end else begin
			if (cfg_write) sys_q <= system_field;
			if (cmd.store) begin
				half_q <= !half_q;
				if (half_q) idx_q <= at_last ? '0 : idx_q + 1'b1;
			end else if (cmd.load) begin
				idx_q <= at_last ? '0 : idx_q + 1'b1;
			end
		end
	end

	// high byte first, then low byte
	always_ff @(posedge clk) begin
		if (cmd.store) begin
			if (half_q) begin
				word_q[idx_q][7:0] <= rx_byte;
			end else begin
				word_q[idx_q][15:8] <= rx_byte;
			end
		end
	end

	always_comb begin
		rd_word = word_q[idx_q];
		rd_chan = rd_word[14:11];
		rd_pos  = rd_word[10:0];
		rd_ok   = ({1'b0, rd_chan} < CHANNEL_COUNT);
		prod    = 18'(rd_pos) * POS_SCALE;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			chan_q <= rd_chan;
			pos_q  <= rd_pos;
			ok_q   <= rd_ok;
			norm_q <= rd_ok ? signed'(prod - NORM_OFFSET) : '0;
			last_q <= at_last;
		end
	end

	assign status.sys_match = (rx_byte == sys_q);
	assign status.last_byte = half_q && at_last;
	assign status.last_word = at_last;

	assign channel_index = chan_q;
	assign position      = pos_q;
	assign in_range      = ok_q;
	assign normalized_q7 = norm_q;
	assign last          = last_q;

endmodule

// ----- src/rc_receiver_frame_decoder.sv -----
// Top level of the RC receiver frame decoder.
// Depends on rcfd_pkg, rcfd_ctrl and rcfd_datapath.
//
// Takes received serial bytes one request at a time and finds channel frames of
// 2 + 2*WORDS_PER_FRAME bytes: a fades byte (ignored), a system byte that must
// match the system_field register, then big-endian 16-bit channel words. While
// the system byte does not match, drop the oldest byte and treat the mismatching
// one as the new fades byte. Once the last byte of a frame is in, emit one result
// request per word, in order: channel_index (word bits 14..11), position (bits
// 10..0), in_range (index below CHANNEL_COUNT), normalized_q7 = position*125 -
// 128000 (zero when out of range) and last on the final word.
// Rate: one byte per cycle while a frame is collected; at frame end the input
// stalls while the sequencer loads the single output register with one decoded
// word per cycle while out_ready does not stall the output. The next frame's
// bytes are taken while the final word still waits in the output register.
// The system_field register is written through the cfg channel, which is always
// ready; write it only while the block is idle.
module rc_receiver_frame_decoder #(
	parameter int unsigned WORDS_PER_FRAME = rcfd_pkg::WORDS_PER_FRAME_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [7:0]         system_field,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         rx_byte,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [3:0]         channel_index,
	output logic [10:0]        position,
	output logic               in_range,
	output logic signed [17:0] normalized_q7,
	output logic               last
);
	import rcfd_pkg::*;

	cmd_t    cmd;
	status_t status;

	// register writes never stall
	assign cfg_ready = 1'b1;

	rcfd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	rcfd_datapath #(
		.WORDS_PER_FRAME (WORDS_PER_FRAME)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_valid && cfg_ready),
		.system_field  (system_field),
		.rx_byte       (rx_byte),
		.cmd           (cmd),
		.status        (status),
		.channel_index (channel_index),
		.position      (position),
		.in_range      (in_range),
		.normalized_q7 (normalized_q7),
		.last          (last)
	);

endmodule

// ----- src/rcfd_checker.sv -----
// Port-level checks for the RC receiver frame decoder, bound to the top level.
// Depends on rcfd_pkg and rc_receiver_frame_decoder_assert.svh.
`include "rc_receiver_frame_decoder_assert.svh"

module rcfd_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [3:0]         channel_index,
	input logic [10:0]        position,
	input logic               in_range,
	input logic signed [17:0] normalized_q7,
	input logic               last
);
	import rcfd_pkg::*;

	// a stalled result holds
	`RCFD_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(channel_index) && $stable(position) && $stable(normalized_q7) && $stable(last))

	`RCFD_ASSERT_SAME(a_range_flag, clk, arst_n, out_valid, in_range == ({1'b0, channel_index} < CHANNEL_COUNT))

	`RCFD_ASSERT_SAME(a_out_of_range_zero, clk, arst_n, out_valid && !in_range, normalized_q7 == 18'sd0)

	// mid-frame results keep the input stalled
	`RCFD_ASSERT_SAME(a_emit_stalls_input, clk, arst_n, out_valid && !last, !in_ready)

endmodule

bind rc_receiver_frame_decoder rcfd_checker u_rcfd_checker (.*);

// ----- dv/rc_receiver_frame_decoder_test.sv -----
// Self-checking testbench for the RC receiver frame decoder: byte requests in, word results out.
// Depends on rcfd_pkg and the rc_receiver_frame_decoder RTL; carries its own frame decoder model.
module rc_receiver_frame_decoder_test;

	import rcfd_pkg::*;

	localparam int CLK_HALF      = 4;
	localparam int RESET_CYCLES  = 5;
	localparam int SETTLE_CYCLES = 32;
	localparam int HOLD_CYCLES   = 64;
	localparam int CYCLE_LIMIT   = 40000;
	localparam int MAX_REPORTS   = 10;
	localparam int FRAME_LEN     = 16;
	localparam int WORDS         = 7;
	localparam int POS_STEP      = 125;
	localparam int POS_BIAS      = 128000;

	// One decoded channel word as it leaves the block.
	typedef struct packed {
		logic [3:0]         channel_index;
		logic [10:0]        position;
		logic               in_range;
		logic signed [17:0] normalized_q7;
		logic               last;
	} word_result_t;

	// Hand-written expectation for one word of a directed frame.
	typedef struct packed {
		logic         typed;
		word_result_t w;
	} word_note_t;

	// Directed row: a single raw byte, or a channel word sent high byte first.
	typedef struct packed {
		logic         is_word;
		logic [15:0]  value;
		logic         typed;
		word_result_t w;
	} dir_row_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [7:0]         system_field;
	logic               in_valid;
	logic               in_ready;
	logic [7:0]         rx_byte;
	logic               out_valid;
	logic               out_ready;
	logic [3:0]         channel_index;
	logic [10:0]        position;
	logic               in_range;
	logic signed [17:0] normalized_q7;
	logic               last;

	// Decoder model state: its own copy of the register and the frame being collected.
	logic [7:0]   sys_field_model;
	int           held_cnt;
	logic [7:0]   frame_buf [0:13];

	word_result_t pending_words [$];
	word_note_t   typed_words [$];
	dir_row_t     directed_rows [11];

	logic [7:0]   sys_setting;
	bit           calm;
	bit           hold_off_req;
	int           sink_idle;
	int           err_cnt;
	int           cycle_cnt;

	rc_receiver_frame_decoder i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.system_field  (system_field),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.rx_byte       (rx_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.channel_index (channel_index),
		.position      (position),
		.in_range      (in_range),
		.normalized_q7 (normalized_q7),
		.last          (last)
	);

	always #CLK_HALF clk = ~clk;

	// Advance the frame model by one accepted byte; on the closing byte queue all seven words.
	task automatic decode_byte(input logic [7:0] b);
		word_result_t w;
		word_note_t   note;
		logic [15:0]  word;
		int           k;
		if (held_cnt == 0) begin
			// fades byte: count it, keep nothing
			held_cnt = 1;
		end else if (held_cnt == 1) begin
			// sync on the system byte; a mismatch simply becomes the new fades byte
			if (b == sys_field_model) held_cnt = 2;
		end else begin
			frame_buf[held_cnt - 2] = b;
			held_cnt++;
			if (held_cnt == FRAME_LEN) begin
				held_cnt = 0;
				for (k = 0; k < WORDS; k++) begin
					word            = {frame_buf[2 * k], frame_buf[2 * k + 1]};
					w.channel_index = word[14:11];
					w.position      = word[10:0];
					w.in_range      = (word[14:11] < CHANNEL_COUNT);
					w.normalized_q7 = w.in_range ?
						18'(POS_STEP * int'(word[10:0]) - POS_BIAS) : '0;
					w.last          = (k == WORDS - 1);
					// directed words carry typed expectations; use them where given
					if (typed_words.size() != 0) begin
						note = typed_words.pop_front();
						if (note.typed) w = note.w;
					end
					pending_words.push_back(w);
				end
			end
		end
	endtask

	// Watch both channels at the edge; values read here are the ones the edge samples.
	always @(posedge clk) begin
		word_result_t got;
		word_result_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) sys_field_model = system_field;
			if (in_valid && in_ready) decode_byte(rx_byte);
			if (out_valid && out_ready) begin
				got = '{channel_index, position, in_range, normalized_q7, last};
				if (pending_words.size() == 0) begin
					err_cnt++;
					if (err_cnt <= MAX_REPORTS)
						$display("unexpected word: idx=%0d pos=%0d rng=%0b q7=%0d last=%0b",
							got.channel_index, got.position, got.in_range,
							got.normalized_q7, got.last);
				end else begin
					want = pending_words.pop_front();
					if (got.channel_index !== want.channel_index ||
					    got.position !== want.position ||
					    got.in_range !== want.in_range ||
					    got.normalized_q7 !== want.normalized_q7 ||
					    got.last !== want.last) begin
						err_cnt++;
						if (err_cnt <= MAX_REPORTS)
							$display("word mismatch: exp idx=%0d pos=%0d rng=%0b q7=%0d last=%0b, %s%0d %s%0d %s%0b %s%0d %s%0b",
								want.channel_index, want.position, want.in_range,
								want.normalized_q7, want.last,
								"got idx=", got.channel_index, "pos=", got.position,
								"rng=", got.in_range, "q7=", got.normalized_q7,
								"last=", got.last);
					end
				end
			end
		end
	end

	// Hard stop if the run hangs.
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Result side: decide out_ready once per edge; bursts of stall, plus one long hold-off
	// on request so the output fills and the block stalls its byte input.
	initial begin
		out_ready = 1'b0;
		sink_idle = 0;
		forever begin
			@(posedge clk);
			if (sink_idle == 0) begin
				if (hold_off_req) begin
					hold_off_req = 1'b0;
					sink_idle = HOLD_CYCLES;
				end else if (!calm && $urandom_range(0, 3) == 0) begin
					sink_idle = $urandom_range(1, 4);
				end
			end
			if (sink_idle > 0) begin
				out_ready <= 1'b0;
				sink_idle--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Offer one byte request and hold it until accepted; returns at the accepting edge.
	task automatic send_byte(input logic [7:0] b);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (!in_ready);
	endtask

	// Drop valid, let every queued word come out, then let the block settle.
	task automatic drain;
		in_valid <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_system_field(input logic [7:0] v);
		sys_setting  = v;
		cfg_valid    <= 1'b1;
		system_field <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Mostly well-formed frames with random words; the rest is noise and cut-short frames.
	task automatic random_phase(input int n_bytes);
		int          sent;
		int          pick;
		int          len;
		int          k;
		logic [15:0] word;
		sent = 0;
		while (sent < n_bytes) begin
			pick = $urandom_range(0, 9);
			if (pick < 7) begin
				send_byte(8'($urandom_range(0, 255)));
				send_byte(sys_setting);
				for (k = 0; k < WORDS; k++) begin
					word = 16'($urandom_range(0, 65535));
					// push some positions to the ends of their range
					if ($urandom_range(0, 5) == 0)
						word[10:0] = $urandom_range(0, 1) ? 11'h7FF : 11'h000;
					send_byte(word[15:8]);
					send_byte(word[7:0]);
				end
				sent += FRAME_LEN;
			end else if (pick < 9) begin
				len = $urandom_range(1, 3);
				repeat (len) send_byte(8'($urandom_range(0, 255)));
				sent += len;
			end else begin
				len = $urandom_range(1, 13);
				send_byte(8'($urandom_range(0, 255)));
				send_byte(sys_setting);
				repeat (len) send_byte(8'($urandom_range(0, 255)));
				sent += 2 + len;
			end
		end
	endtask

	initial begin
		int i;
		clk             = 1'b0;
		arst_n          = 1'b0;
		cfg_valid       = 1'b0;
		system_field    = '0;
		in_valid        = 1'b0;
		rx_byte         = '0;
		calm            = 1'b0;
		hold_off_req    = 1'b0;
		err_cnt         = 0;
		cycle_cnt       = 0;
		held_cnt        = 0;
		sys_field_model = SYSTEM_FIELD_RST;
		sys_setting     = SYSTEM_FIELD_RST;

		// Directed frame under the reset system value: a fades byte equal to the system
		// value, two mismatching system bytes that each become the new fades byte, the
		// sync byte, then extreme words (index 0 / 11 / 12 / 15, position 0 / 2047,
		// phase bit set) with their results typed in, and a few left to the model.
		directed_rows = '{
			'{1'b0, 16'h00B2, 1'b0, '0},
			'{1'b0, 16'h0055, 1'b0, '0},
			'{1'b0, 16'h00B3, 1'b0, '0},
			'{1'b0, 16'h00B2, 1'b0, '0},
			'{1'b1, 16'h0000, 1'b1, '{4'd0,  11'd0,    1'b1, -18'sd128000, 1'b0}},
			'{1'b1, 16'h5FFF, 1'b1, '{4'd11, 11'd2047, 1'b1, 18'sd127875,  1'b0}},
			'{1'b1, 16'h6000, 1'b1, '{4'd12, 11'd0,    1'b0, 18'sd0,       1'b0}},
			'{1'b1, 16'hFFFF, 1'b1, '{4'd15, 11'd2047, 1'b0, 18'sd0,       1'b0}},
			'{1'b1, 16'h8400, 1'b0, '0},
			'{1'b1, 16'h0801, 1'b0, '0},
			'{1'b1, 16'h2A5C, 1'b0, '0}
		};

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < 11; i++) begin
			if (directed_rows[i].is_word) begin
				typed_words.push_back('{directed_rows[i].typed, directed_rows[i].w});
				send_byte(directed_rows[i].value[15:8]);
				send_byte(directed_rows[i].value[7:0]);
			end else begin
				send_byte(directed_rows[i].value[7:0]);
			end
		end
		drain();

		// Lowest system value; stall the result side for a long stretch meanwhile.
		write_system_field(8'h00);
		hold_off_req = 1'b1;
		random_phase(25);
		drain();

		write_system_field(8'hFF);
		random_phase(25);
		drain();

		write_system_field(8'($urandom_range(0, 255)));
		random_phase(20);
		drain();

		// Back to the reset value and run the tail with no idling on either side.
		write_system_field(SYSTEM_FIELD_RST);
		calm = 1'b1;
		random_phase(20);
		drain();

		if (err_cnt == 0 && pending_words.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// ----- rc_receiver_frame_decoder.f -----
+incdir+src
src/rcfd_pkg.sv
src/rcfd_ctrl.sv
src/rcfd_datapath.sv
src/rc_receiver_frame_decoder.sv
src/rcfd_checker.sv
dv/rc_receiver_frame_decoder_test.sv
